>>> rtl/core/hps_pkg.sv
// shared types and constants for the haptic pulse sequencer
package hps_pkg;

   localparam int CHANNELS_DEF     = 4;
   localparam int BUFFER_DEPTH_DEF = 16;
   localparam int OP_W             = 2;
   localparam int TIME_W           = 32;
   localparam int DUR_W            = 16;
   localparam int LEN_W            = 8;

   typedef enum logic [OP_W-1:0] {
      OP_TICK = 2'd0,
      OP_PUSH = 2'd1,
      OP_STOP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_PLAYING = 3'b010,
      MODE_STOPPED = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      ST_WAIT = 2'b01,
      ST_EXEC = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> rtl/core/hps_store.sv
// pulse ring store, one write port and one registered read port
module hps_store #(
   parameter int CHANNELS     = hps_pkg::CHANNELS_DEF,
   parameter int BUFFER_DEPTH = hps_pkg::BUFFER_DEPTH_DEF,
   localparam int IDX_W       = $clog2(BUFFER_DEPTH),
   localparam int ENTRY_W     = CHANNELS + hps_pkg::DUR_W
) (
   input  logic                 clock,
   input  hps_pkg::mem_ctl_type mem_ctl,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [ENTRY_W-1:0]   wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [ENTRY_W-1:0]   rd_data
);

   logic [ENTRY_W-1:0] mem [BUFFER_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hps_ctrl.sv
// sequencer control: item capture, playback state machine and drive registers
module hps_ctrl #(
   parameter int CHANNELS     = hps_pkg::CHANNELS_DEF,
   parameter int BUFFER_DEPTH = hps_pkg::BUFFER_DEPTH_DEF,
   localparam int IDX_W       = $clog2(BUFFER_DEPTH),
   localparam int ENTRY_W     = CHANNELS + hps_pkg::DUR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hps_pkg::OP_W-1:0]    req_operation,
   input  logic [hps_pkg::TIME_W-1:0]  req_now_ms,
   input  logic [CHANNELS-1:0]         req_pulse_channels,
   input  logic [hps_pkg::DUR_W-1:0]   req_pulse_duration_ms,
   input  logic [hps_pkg::LEN_W-1:0]   req_sequence_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_drive_enable,
   output logic [CHANNELS-1:0]         rsp_drive_a,
   output logic [CHANNELS-1:0]         rsp_drive_b,
   output logic                        rsp_busy_res,
   output hps_pkg::mem_ctl_type        mem_ctl,
   output logic [IDX_W-1:0]            wr_addr,
   output logic [ENTRY_W-1:0]          wr_data,
   output logic [IDX_W-1:0]            rd_addr,
   input  logic [ENTRY_W-1:0]          rd_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
   localparam logic [hps_pkg::LEN_W:0] MAX_LEN = (hps_pkg::LEN_W + 1)'(BUFFER_DEPTH);

   hps_pkg::seq_state_type       state_ff, state_in;
   hps_pkg::mode_type            mode_ff, mode_in;
   logic                         stop_req_ff, stop_req_in;
   logic [IDX_W-1:0]             wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         applied_ff, applied_in;
   logic [hps_pkg::TIME_W-1:0]   start_ff, start_in;
   logic                         drv_en_ff, drv_en_in;
   logic [CHANNELS-1:0]          drv_b_ff, drv_b_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [hps_pkg::OP_W-1:0]     op_ff;
   logic [hps_pkg::TIME_W-1:0]   now_ff;
   logic [CHANNELS-1:0]          chan_ff;
   logic [hps_pkg::DUR_W-1:0]    dur_ff;
   logic [hps_pkg::LEN_W-1:0]    len_ff;

   logic                         accept;
   logic                         commit;
   logic                         not_empty;
   logic                         elapsed;
   logic [hps_pkg::TIME_W-1:0]   age;
   logic [CHANNELS-1:0]          entry_chan;
   logic [hps_pkg::DUR_W-1:0]    entry_dur;

   assign req_stall = (state_ff != hps_pkg::ST_WAIT);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == hps_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign entry_chan = rd_data[CHANNELS-1:0];
   assign entry_dur  = rd_data[ENTRY_W-1:CHANNELS];
   assign not_empty  = (wr_idx_ff != rd_idx_ff);
   assign age        = now_ff - start_ff;
   assign elapsed    = (age >= {{(hps_pkg::TIME_W - hps_pkg::DUR_W){1'b0}}, entry_dur});

   assign rd_addr       = rd_idx_ff;
   assign wr_addr       = wr_idx_ff;
   assign wr_data       = {dur_ff, chan_ff};
   assign mem_ctl.rd_en = accept;
   assign mem_ctl.wr_en = commit && (op_ff == hps_pkg::OP_PUSH)
                          && ({1'b0, len_ff} <= MAX_LEN);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      stop_req_in = stop_req_ff;
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      applied_in  = applied_ff;
      start_in    = start_ff;
      drv_en_in   = drv_en_ff;
      drv_b_in    = drv_b_ff;

      unique case (state_ff)
         hps_pkg::ST_WAIT: begin
            if (accept) begin
               state_in = hps_pkg::ST_EXEC;
            end
         end
         hps_pkg::ST_EXEC: begin
            if (commit) begin
               state_in = hps_pkg::ST_WAIT;
               unique case (op_ff)
                  hps_pkg::OP_TICK: begin
                     unique case (mode_ff)
                        hps_pkg::MODE_IDLE: begin
                           drv_en_in = 1'b0;
                           drv_b_in  = '1;
                           if (not_empty) begin
                              mode_in     = hps_pkg::MODE_PLAYING;
                              stop_req_in = 1'b0;
                              start_in    = now_ff;
                           end
                        end
                        hps_pkg::MODE_PLAYING: begin
                           if (stop_req_ff) begin
                              mode_in = hps_pkg::MODE_STOPPED;
                           end
                           if (not_empty) begin
                              if (!applied_ff) begin
                                 applied_in = 1'b1;
                                 drv_en_in  = 1'b1;
                                 drv_b_in   = ~entry_chan;
                              end
                              if (elapsed) begin
                                 start_in   = now_ff;
                                 rd_idx_in  = (rd_idx_ff == LAST_IDX) ? '0
                                              : rd_idx_ff + 1'b1;
                                 applied_in = 1'b0;
                              end
                           end else begin
                              mode_in = hps_pkg::MODE_STOPPED;
                           end
                        end
                        hps_pkg::MODE_STOPPED: begin
                           drv_en_in = 1'b0;
                           drv_b_in  = '1;
                           mode_in   = hps_pkg::MODE_IDLE;
                        end
                        default: begin
                           mode_in = hps_pkg::MODE_IDLE;
                        end
                     endcase
                  end
                  hps_pkg::OP_PUSH: begin
                     if (mem_ctl.wr_en) begin
                        wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
                     end
                  end
                  hps_pkg::OP_STOP: begin
                     stop_req_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = hps_pkg::ST_WAIT;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hps_pkg::ST_WAIT;
         mode_ff      <= hps_pkg::MODE_IDLE;
         stop_req_ff  <= 1'b1;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         applied_ff   <= 1'b0;
         start_ff     <= '0;
         drv_en_ff    <= 1'b0;
         drv_b_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         stop_req_ff  <= stop_req_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         applied_ff   <= applied_in;
         start_ff     <= start_in;
         drv_en_ff    <= drv_en_in;
         drv_b_ff     <= drv_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         now_ff  <= req_now_ms;
         chan_ff <= req_pulse_channels;
         dur_ff  <= req_pulse_duration_ms;
         len_ff  <= req_sequence_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_enable = drv_en_ff;
   assign rsp_drive_a      = '1;
   assign rsp_drive_b      = drv_b_ff;
   assign rsp_busy_res     = (mode_ff == hps_pkg::MODE_PLAYING);

endmodule

>>> rtl/core/haptic_pulse_sequencer.sv
// haptic pulse sequencer top level
//
// req channel: one item per handshake (req_valid high, req_stall low).
//   tick items step the idle/playing/stopped machine with req_now_ms,
//   push items store a pulse in the ring, stop items request a stop.
// rsp channel: exactly one item per accepted req item, in order, carrying
//   the drive enable, both h-bridge pin masks and the playing flag as they
//   stand after that item.
// order: the req item and the ring entry at the read index are registered
//   when the item is accepted, read from the synchronous pulse store; the
//   state and the response are then updated from them, once no previous
//   response is stalled on rsp.
// a new req item is taken only after the last one's update, which follows
//   its store read; req_stall is high while an item is being worked on.
// a finished response sits in an output register; the next req item is
//   taken while it waits, and its update holds until the response is taken.
// reset (synchronous): idle, stop pending, ring empty, drive disabled with
//   every channel braked; the store itself is not cleared.
module haptic_pulse_sequencer #(
   parameter int CHANNELS     = hps_pkg::CHANNELS_DEF,
   parameter int BUFFER_DEPTH = hps_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hps_pkg::OP_W-1:0]    req_operation,
   input  logic [hps_pkg::TIME_W-1:0]  req_now_ms,
   input  logic [CHANNELS-1:0]         req_pulse_channels,
   input  logic [hps_pkg::DUR_W-1:0]   req_pulse_duration_ms,
   input  logic [hps_pkg::LEN_W-1:0]   req_sequence_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_drive_enable,
   output logic [CHANNELS-1:0]         rsp_drive_a,
   output logic [CHANNELS-1:0]         rsp_drive_b,
   output logic                        rsp_busy_res
);

   localparam int IDX_W   = $clog2(BUFFER_DEPTH);
   localparam int ENTRY_W = CHANNELS + hps_pkg::DUR_W;

   hps_pkg::mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ENTRY_W-1:0]   rd_data;

   hps_ctrl #(
      .CHANNELS     (CHANNELS),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_now_ms            (req_now_ms),
      .req_pulse_channels    (req_pulse_channels),
      .req_pulse_duration_ms (req_pulse_duration_ms),
      .req_sequence_length   (req_sequence_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive_enable      (rsp_drive_enable),
      .rsp_drive_a           (rsp_drive_a),
      .rsp_drive_b           (rsp_drive_b),
      .rsp_busy_res          (rsp_busy_res),
      .mem_ctl               (mem_ctl),
      .wr_addr               (wr_addr),
      .wr_data               (wr_data),
      .rd_addr               (rd_addr),
      .rd_data               (rd_data)
   );

   hps_store #(
      .CHANNELS     (CHANNELS),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> rtl/core/hps_checker.sv
// port-level checks for the haptic pulse sequencer, bound to the top level
module hps_checker #(
   parameter int CHANNELS = hps_pkg::CHANNELS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_drive_enable,
   input logic [CHANNELS-1:0]         rsp_drive_a,
   input logic [CHANNELS-1:0]         rsp_drive_b,
   input logic                        rsp_busy_res
);

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req taken while previous item in progress");

   // a pin is always high, braking or driving
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (&rsp_drive_a))
      else $error("drive_a not all ones");

   // disabled drive means every channel braked
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_enable) |-> (&rsp_drive_b))
      else $error("disabled drive with channel not braked");

   // nothing pending or playing straight after reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !rsp_busy_res && !req_stall))
      else $error("state not cleared by reset");

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive_b)
                                    && $stable(rsp_busy_res)))
      else $error("stalled rsp item changed");

endmodule

bind haptic_pulse_sequencer hps_checker #(.CHANNELS(CHANNELS)) u_hps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drive_enable (rsp_drive_enable),
   .rsp_drive_a      (rsp_drive_a),
   .rsp_drive_b      (rsp_drive_b),
   .rsp_busy_res     (rsp_busy_res)
);
